@@ hdl/pscg_pkg.sv @@
`default_nettype none
package pscg_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int STROKE_SLOTS = 2;
  localparam int CNT_W      = 2;

  typedef enum logic [1:0] {
    REQ_MOTION  = 2'd0,
    REQ_PRESS   = 2'd1,
    REQ_RELEASE = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    DIR_UNKNOWN = 3'd0,
    DIR_RIGHT   = 3'd1,
    DIR_LEFT    = 3'd2,
    DIR_DOWN    = 3'd3,
    DIR_UP      = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_BACK    = 2'd2
  } action_t;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STROKE_SLOTS);

  typedef struct packed {
    logic classed;
    dir_t dir;
  } class_t;

  typedef struct packed {
    logic             armed;
    logic [CNT_W-1:0] stroke_count;
  } core_status_t;

endpackage
`default_nettype wire

@@ hdl/pscg_classify.sv @@
`default_nettype none
module pscg_classify (
  input  wire logic signed [pscg_pkg::COORD_BITS-1:0] x_pos,
  input  wire logic signed [pscg_pkg::COORD_BITS-1:0] y_pos,
  input  wire logic signed [pscg_pkg::COORD_BITS-1:0] ref_x,
  input  wire logic signed [pscg_pkg::COORD_BITS-1:0] ref_y,
  output pscg_pkg::class_t                            cls
);
  import pscg_pkg::*;

  logic signed [DIFF_W-1:0] dx, dy;
  logic        [DIFF_W-1:0] ax, ay;
  logic        [DIFF_W:0]   ax2, ay2;

  // offsets at one extra bit, exact for any pair of coordinates
  assign dx = DIFF_W'(x_pos) - DIFF_W'(ref_x);
  assign dy = DIFF_W'(y_pos) - DIFF_W'(ref_y);
  assign ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign ax2 = {ax, 1'b0};
  assign ay2 = {ay, 1'b0};

  always_comb begin
    cls.classed = 1'b0;
    cls.dir     = DIR_UNKNOWN;
    if ({1'b0, ax} > ay2) begin
      cls.classed = 1'b1;
      cls.dir     = dx[DIFF_W-1] ? DIR_LEFT : DIR_RIGHT;
    end else if ({1'b0, ay} > ax2) begin
      cls.classed = 1'b1;
      cls.dir     = dy[DIFF_W-1] ? DIR_UP : DIR_DOWN;
    end
  end

endmodule
`default_nettype wire

@@ hdl/pscg_core.sv @@
`default_nettype none
module pscg_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   step,
  input  wire logic [1:0]                             req_type,
  input  wire logic [3:0]                             button_id,
  input  wire logic signed [pscg_pkg::COORD_BITS-1:0] x_pos,
  input  wire logic signed [pscg_pkg::COORD_BITS-1:0] y_pos,
  input  wire logic [3:0]                             trigger_button,
  output pscg_pkg::action_t                           action,
  output pscg_pkg::core_status_t                      status
);
  import pscg_pkg::*;

  logic                           armed_r, armed_nxt;
  logic                           have_ref_r, have_ref_nxt;
  logic signed [COORD_BITS-1:0]   ref_x_r, ref_x_nxt;
  logic signed [COORD_BITS-1:0]   ref_y_r, ref_y_nxt;
  dir_t                           store0_r, store0_nxt;
  dir_t                           store1_r, store1_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  dir_t                           prev_dir_r, prev_dir_nxt;
  class_t                         cls;
  logic                           is_trigger;

  pscg_classify u_classify (
    .x_pos (x_pos),
    .y_pos (y_pos),
    .ref_x (ref_x_r),
    .ref_y (ref_y_r),
    .cls   (cls)
  );

  assign is_trigger = (button_id == trigger_button);

  always_comb begin
    armed_nxt    = armed_r;
    have_ref_nxt = have_ref_r;
    ref_x_nxt    = ref_x_r;
    ref_y_nxt    = ref_y_r;
    store0_nxt   = store0_r;
    store1_nxt   = store1_r;
    count_nxt    = count_r;
    prev_dir_nxt = prev_dir_r;
    action       = ACT_NONE;
    case (req_type)
      REQ_MOTION: begin
        if (armed_r && count_r < FULL_COUNT) begin
          if (!have_ref_r) begin
            have_ref_nxt = 1'b1;
            ref_x_nxt    = x_pos;
            ref_y_nxt    = y_pos;
          end else if (cls.classed) begin
            ref_x_nxt = x_pos;
            ref_y_nxt = y_pos;
            if (cls.dir != prev_dir_r) begin
              if (count_r[0]) store1_nxt = cls.dir;
              else            store0_nxt = cls.dir;
              count_nxt    = count_r + CNT_W'(1);
              prev_dir_nxt = cls.dir;
            end
          end
        end
      end
      REQ_PRESS: begin
        armed_nxt = is_trigger;
      end
      REQ_RELEASE: begin
        if (is_trigger) begin
          if (armed_r) begin
            if (count_r == FULL_COUNT && store0_r == DIR_DOWN) begin
              if (store1_r == DIR_RIGHT)     action = ACT_FORWARD;
              else if (store1_r == DIR_LEFT) action = ACT_BACK;
            end
            count_nxt    = '0;
            have_ref_nxt = 1'b0;
            ref_x_nxt    = '0;
            ref_y_nxt    = '0;
          end
          armed_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      have_ref_r <= 1'b0;
      ref_x_r    <= '0;
      ref_y_r    <= '0;
      store0_r   <= DIR_UNKNOWN;
      store1_r   <= DIR_UNKNOWN;
      count_r    <= '0;
      prev_dir_r <= DIR_UNKNOWN;
    end else if (step) begin
      armed_r    <= armed_nxt;
      have_ref_r <= have_ref_nxt;
      ref_x_r    <= ref_x_nxt;
      ref_y_r    <= ref_y_nxt;
      store0_r   <= store0_nxt;
      store1_r   <= store1_nxt;
      count_r    <= count_nxt;
      prev_dir_r <= prev_dir_nxt;
    end
  end

  assign status.armed        = armed_r;
  assign status.stroke_count = count_r;

endmodule
`default_nettype wire

@@ hdl/pointer_stroke_gesture_recognizer.sv @@
`default_nettype none
// path: a request passes the input register, then the result register, before its result
//   can be accepted
// throughput: one request per cycle unless the result side stalls; the gesture state updates
//   in the same cycle that the request moves from the input register into the result register
// reset: rst_n synchronous active low, clears both stages, the gesture state and sets
//   trigger_button to 2
module pointer_stroke_gesture_recognizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // button_id[3:0], x_pos[19:4], y_pos[35:20], zero pad
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // action[1:0], zero pad
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import pscg_pkg::*;

  // configuration: trigger_button at byte addresses 0 to 3, reads as zero from 4 up
  logic [3:0] trigger_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {28'd0, trigger_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_r <= 4'd2;
    end else if (cfg_wr) begin
      trigger_r <= cfg_pwdata[3:0];
    end
  end

  // input register
  logic                         in_valid_r;
  logic [1:0]                   req_type_r;
  logic [3:0]                   button_r;
  logic signed [COORD_BITS-1:0] x_r, y_r;
  logic                         advance;
  logic                         in_fire;

  // the input stage moves on whenever the result register is free or being drained
  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r <= in_tuser;
      button_r   <= in_tdata[3:0];
      x_r        <= in_tdata[19:4];
      y_r        <= in_tdata[35:20];
    end
  end

  // gesture state and classification
  action_t      action;
  core_status_t status;

  pscg_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .req_type       (req_type_r),
    .button_id      (button_r),
    .x_pos          (x_r),
    .y_pos          (y_r),
    .trigger_button (trigger_r),
    .action         (action),
    .status         (status)
  );

  // result register
  action_t action_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (advance) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action_r <= action;
    end
  end

  assign out_tdata = {6'd0, action_r};

  // the stroke count never runs past the full store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.stroke_count <= FULL_COUNT)
    else $error("stroke count beyond store depth");

  // a recognized command leaves the block disarmed with an empty store
  a_complete_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && action != ACT_NONE) |=> (!status.armed && status.stroke_count == '0))
    else $error("completion did not clear gesture state");

  // a command only comes from a full store while armed
  a_action_source: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && action != ACT_NONE) |-> (status.armed && status.stroke_count == FULL_COUNT))
    else $error("command without a full armed gesture");

  // the result register never holds an undefined code
  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3))
    else $error("undefined action code");

endmodule
`default_nettype wire

@@ tb/sv/gesture_checker.sv @@
module gesture_checker #(
  parameter logic [2:0] TRIGGER_ADDR = 3'd0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,   // button_id[3:0], x_pos[19:4], y_pos[35:20], zero pad
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,  // action[1:0], zero pad
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic [31:0] cfg_prdata,
  input  wire logic        cfg_pready,
  output int               mismatches,
  output int               pending,
  output int               results,
  output int               navigations
);
  import pscg_pkg::*;

  logic [3:0]       trigger;
  logic             armed;
  logic             have_ref;
  logic [15:0]      ref_x;
  logic [15:0]      ref_y;
  dir_t             strokes [STROKE_SLOTS];
  logic [CNT_W-1:0] stroke_cnt;
  dir_t             prev_dir;
  action_t          expected_actions [$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // gesture state update for one request, returns the action it yields
  function automatic action_t predict_action(input logic [1:0] kind, input logic [3:0] btn,
                                             input logic [15:0] px, input logic [15:0] py);
    action_t           act;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]        ax;
    logic [16:0]        ay;
    dir_t               dir;
    logic               classed;
    act = ACT_NONE;
    dir = DIR_UNKNOWN;
    case (kind)
      REQ_MOTION: begin
        if (armed && stroke_cnt != FULL_COUNT) begin
          if (!have_ref) begin
            ref_x    = px;
            ref_y    = py;
            have_ref = 1'b1;
          end else begin
            dx = {px[15], px} - {ref_x[15], ref_x};
            dy = {py[15], py} - {ref_y[15], ref_y};
            ax = dx[16] ? 17'(-dx) : 17'(dx);
            ay = dy[16] ? 17'(-dy) : 17'(dy);
            classed = 1'b1;
            if ({1'b0, ax} > {ay, 1'b0}) dir = (dx > 0) ? DIR_RIGHT : DIR_LEFT;
            else if ({1'b0, ay} > {ax, 1'b0}) dir = (dy > 0) ? DIR_DOWN : DIR_UP;
            else classed = 1'b0;
            if (classed) begin
              ref_x = px;
              ref_y = py;
              if (dir != prev_dir) begin
                strokes[stroke_cnt[0]] = dir;
                stroke_cnt = stroke_cnt + 1'b1;
                prev_dir = dir;
              end
            end
          end
        end
      end
      REQ_PRESS: armed = (btn == trigger);
      REQ_RELEASE: begin
        if (btn == trigger) begin
          if (armed) begin
            if (stroke_cnt == FULL_COUNT && strokes[0] == DIR_DOWN) begin
              if (strokes[1] == DIR_RIGHT) act = ACT_FORWARD;
              else if (strokes[1] == DIR_LEFT) act = ACT_BACK;
            end
            stroke_cnt = '0;
            have_ref   = 1'b0;
            ref_x      = '0;
            ref_y      = '0;
          end
          armed = 1'b0;
        end
      end
      default: ;
    endcase
    return act;
  endfunction

  always @(posedge clk) begin : watch
    action_t want;
    action_t got;
    if (!rst_n) begin
      trigger    = 4'd2;
      armed      = 1'b0;
      have_ref   = 1'b0;
      ref_x      = '0;
      ref_y      = '0;
      strokes[0] = DIR_UNKNOWN;
      strokes[1] = DIR_UNKNOWN;
      stroke_cnt = '0;
      prev_dir   = DIR_UNKNOWN;
      expected_actions.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == TRIGGER_ADDR) begin
        if (cfg_pwrite) trigger = cfg_pwdata[3:0];
        else if (cfg_prdata[3:0] != trigger)
          report_mismatch($sformatf("trigger_button reads %0d, expected %0d",
                                    cfg_prdata[3:0], trigger));
      end
      if (in_tvalid && in_tready)
        expected_actions.push_back(predict_action(in_tuser, in_tdata[3:0],
                                                  in_tdata[19:4], in_tdata[35:20]));
      if (out_tvalid && out_tready) begin
        got = action_t'(out_tdata[1:0]);
        results++;
        if (expected_actions.size() == 0) begin
          report_mismatch($sformatf("result action %0d with no request outstanding", got));
        end else begin
          want = expected_actions.pop_front();
          if (got != want) report_mismatch($sformatf("action %0d, expected %0d", got, want));
          else if (got != ACT_NONE) navigations++;
        end
      end
    end
    pending = expected_actions.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import pscg_pkg::*;

  localparam logic [2:0] TRIGGER_ADDR = 3'd0;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;    // event kind the block must ignore
  localparam logic [3:0] TRIG_RESET   = 4'd2;    // trigger_button after reset
  localparam logic [3:0] OTHER_BUTTON = 4'd5;
  localparam int         LATENCY      = 2;
  localparam int         HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // button_id[3:0], x_pos[19:4], y_pos[35:20], zero pad
  logic [1:0]  in_tuser;    // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // action[1:0], zero pad
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          mismatches;
  int          pending;
  int          results;
  int          navigations;

  // stimulus bookkeeping
  int          items_sent    = 0;
  int          burst_left    = 0;
  bit          no_gaps       = 1'b0;
  int          hold_asked    = 0;
  int          settings_used = 1;
  logic [3:0]  trig_now      = TRIG_RESET;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pointer_stroke_gesture_recognizer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  gesture_checker #(.TRIGGER_ADDR(TRIGGER_ADDR)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .pending     (pending),
    .results     (results),
    .navigations (navigations)
  );

  // offer one request, starting and ending at a falling edge
  // bursts of random length, random gaps between them
  task automatic send_req(input logic [1:0] kind, input logic [3:0] btn,
                          input logic [15:0] px, input logic [15:0] py);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, py, px, btn};
    // accepted at the first rising edge that sees tready
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // one register transfer: setup, access, then idle with the select low
  task automatic cfg_access(input logic write, input logic [3:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= TRIGGER_ADDR;
    cfg_pwdata  <= 32'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    if (write) begin
      trig_now = value;
      settings_used++;
    end
  endtask

  // stop offering and wait until every request has its result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // motion sample offset from the current point; DIR_UNKNOWN gives an ambiguous offset
  task automatic move(input dir_t dir, inout logic [15:0] px, inout logic [15:0] py);
    int major;
    int minor;
    major = $urandom_range(64, 3000);
    if (dir == DIR_UNKNOWN) minor = $urandom_range((major + 1) / 2, major);
    else minor = $urandom_range(0, major / 2 - 1);
    if ($urandom_range(0, 1)) minor = -minor;
    case (dir)
      DIR_RIGHT: begin px = px + 16'(major); py = py + 16'(minor); end
      DIR_LEFT:  begin px = px - 16'(major); py = py + 16'(minor); end
      DIR_DOWN:  begin py = py + 16'(major); px = px + 16'(minor); end
      DIR_UP:    begin py = py - 16'(major); px = px + 16'(minor); end
      default: begin
        // neither axis dominates, sometimes no offset at all
        if ($urandom_range(0, 9) != 0) begin
          if ($urandom_range(0, 1)) begin
            px = px + ($urandom_range(0, 1) ? 16'(major) : -16'(major));
            py = py + 16'(minor);
          end else begin
            py = py + ($urandom_range(0, 1) ? 16'(major) : -16'(major));
            px = px + 16'(minor);
          end
        end
      end
    endcase
    send_req(REQ_MOTION, 4'($urandom), px, py);
  endtask

  // fully random request, reaches every kind, button and coordinate bit
  task automatic noise_req();
    send_req(2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // mostly well formed gesture with random geometry, with broken variants mixed in
  task automatic random_gesture();
    logic [15:0] gx;
    logic [15:0] gy;
    logic [3:0]  other;
    int          n;
    other = trig_now + 4'($urandom_range(1, 15));
    gx = 16'($urandom_range(0, 16000)) - 16'd8000;
    gy = 16'($urandom_range(0, 16000)) - 16'd8000;
    // another button first disarms
    if ($urandom_range(0, 9) == 0) send_req(REQ_PRESS, other, 16'($urandom), 16'($urandom));
    if ($urandom_range(0, 9) != 0) send_req(REQ_PRESS, trig_now, 16'($urandom), 16'($urandom));
    // reference point
    send_req(REQ_MOTION, 4'($urandom), gx, gy);
    if ($urandom_range(0, 99) < 70) begin
      // down then right or left, with detours
      if ($urandom_range(0, 3) == 0) move($urandom_range(0, 1) ? DIR_UP : DIR_RIGHT, gx, gy);
      move(DIR_DOWN, gx, gy);
      if ($urandom_range(0, 2) == 0) move(DIR_UNKNOWN, gx, gy);
      if ($urandom_range(0, 3) == 0) move(DIR_DOWN, gx, gy);
      move($urandom_range(0, 1) ? DIR_RIGHT : DIR_LEFT, gx, gy);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) move(dir_t'(3'($urandom_range(0, 4))), gx, gy);
    end
    // motion once the store is usually full
    if ($urandom_range(0, 3) == 0) move(dir_t'(3'($urandom_range(0, 4))), gx, gy);
    if ($urandom_range(0, 9) == 0) send_req(REQ_RELEASE, other, 16'($urandom), 16'($urandom));
    if ($urandom_range(0, 11) == 0) send_req(REQ_PRESS, other, 16'($urandom), 16'($urandom));
    if ($urandom_range(0, 9) != 0)
      send_req(REQ_RELEASE, trig_now, 16'($urandom), 16'($urandom));
  endtask

  task automatic random_until(input int target);
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 15) noise_req();
      else random_gesture();
    end
  endtask

  // result side: stall pattern of its own, plus long hold-offs on request
  initial begin : receiver
    int mode;
    int stretch;
    int holds_served;
    out_tready   = 1'b0;
    mode         = 0;
    stretch      = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != holds_served) begin
        // long stall so the pipeline fills and input tready drops
        holds_served = hold_asked;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 3);
          stretch = $urandom_range(16, 80);
        end
        stretch--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 4) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #1200000;
    $display("pointer_stroke_gesture_recognizer regression: fail");
    $finish;
  end

  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset value of the trigger register
    cfg_access(1'b0, 4'd0);

    // directed: disarmed trigger release, unused kind, motion while disarmed
    send_req(REQ_RELEASE, TRIG_RESET, 16'd0, 16'd0);
    send_req(REQ_UNUSED, TRIG_RESET, 16'h7fff, 16'h8000);
    send_req(REQ_MOTION, 4'd0, 16'd100, 16'd100);
    // forward with offsets at full range: down then right
    send_req(REQ_PRESS, TRIG_RESET, 16'd0, 16'd0);
    send_req(REQ_MOTION, 4'hf, 16'h8000, 16'h8000);
    send_req(REQ_MOTION, 4'd0, 16'h8000, 16'h7fff);
    send_req(REQ_MOTION, 4'd0, 16'h7fff, 16'h7fff);
    // store full, motion ignored; other button release ignored
    send_req(REQ_MOTION, 4'd0, 16'd0, 16'd0);
    send_req(REQ_RELEASE, OTHER_BUTTON, 16'd0, 16'd0);
    send_req(REQ_RELEASE, TRIG_RESET, 16'd0, 16'd0);
    // zero offset, then exactly twice the other axis: both ambiguous
    send_req(REQ_PRESS, TRIG_RESET, 16'd0, 16'd0);
    send_req(REQ_MOTION, 4'd0, 16'd0, 16'd0);
    send_req(REQ_MOTION, 4'd0, 16'd0, 16'd0);
    send_req(REQ_MOTION, 4'd0, 16'd200, 16'd100);
    // down then left, but another press disarms before the release
    send_req(REQ_MOTION, 4'd0, 16'd0, 16'd256);
    send_req(REQ_MOTION, 4'd0, 16'hfe00, 16'd266);
    send_req(REQ_PRESS, OTHER_BUTTON, 16'd0, 16'd0);
    send_req(REQ_RELEASE, TRIG_RESET, 16'd0, 16'd0);
    // strokes survive, so a bare press and release gives back
    send_req(REQ_PRESS, TRIG_RESET, 16'd0, 16'd0);
    send_req(REQ_RELEASE, TRIG_RESET, 16'd0, 16'd0);
    // up, repeated up moves the point only, then down: no command
    send_req(REQ_PRESS, TRIG_RESET, 16'd0, 16'd0);
    send_req(REQ_MOTION, 4'd0, 16'd0, 16'd0);
    send_req(REQ_MOTION, 4'd0, 16'd10, 16'hf060);
    send_req(REQ_MOTION, 4'd0, 16'd10, 16'he0c0);
    send_req(REQ_MOTION, 4'd0, 16'd0, 16'd0);
    send_req(REQ_RELEASE, TRIG_RESET, 16'd0, 16'd0);

    random_until(150);

    // highest trigger button, with a long stall of the result side
    drain();
    cfg_access(1'b1, 4'd15);
    cfg_access(1'b0, 4'd0);
    hold_asked++;
    no_gaps = 1'b1;
    repeat (3) random_gesture();
    no_gaps = 1'b0;
    random_until(250);

    // lowest trigger button
    drain();
    cfg_access(1'b1, 4'd0);
    cfg_access(1'b0, 4'd0);
    random_until(330);

    // some middle value
    drain();
    cfg_access(1'b1, 4'($urandom_range(1, 14)));
    cfg_access(1'b0, 4'd0);
    random_until(420);

    // let the two pipeline stages run dry
    drain();
    repeat (LATENCY + 4) @(negedge clk);

    $display("covered %0d requests over %0d trigger button settings", items_sent,
             settings_used);
    $display("checked %0d results, %0d of them navigation commands", results, navigations);
    if (mismatches == 0) begin
      $display("pointer_stroke_gesture_recognizer regression: pass");
    end else begin
      $display("pointer_stroke_gesture_recognizer regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pscg_pkg.sv
hdl/pscg_classify.sv
hdl/pscg_core.sv
hdl/pointer_stroke_gesture_recognizer.sv
tb/sv/gesture_checker.sv
tb/sv/testbench.sv
